[rtl/core/ptm_pkg.sv]
// Package for the pose to transform matrix unit: widths, fixed-point constants,
// and the rounding/saturation helper. No dependencies.
package ptm_pkg;
  localparam int OUT_FRAC_BITS = 16;
  localparam int ROT_W   = 34;  // Q28 rotation element, |r| <= 2^32 for any Q2.14 input
  localparam int PROD_W  = 66;  // rotation times 32-bit operand
  localparam int ACC_W   = 68;  // sum of three products

  typedef logic signed [ROT_W-1:0]  rot_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  typedef struct packed {
    logic       valid;
    logic       view;
  } ctl_t;

  localparam logic signed [31:0] ONE_OUT = 32'(64'sd1 <<< OUT_FRAC_BITS);

  // round half up by sh bits, saturate to 32 bits signed
  function automatic logic signed [31:0] rnd_sat(input acc_t v, input int sh);
    logic signed [ACC_W:0] t;
    logic signed [ACC_W:0] q;
    begin
      t = {v[ACC_W-1], v} + ((ACC_W+1)'(1) <<< (sh - 1));
      q = t >>> sh;
      if (q > (ACC_W+1)'(64'sh7FFFFFFF)) rnd_sat = 32'sh7FFFFFFF;
      else if (q < -(ACC_W+1)'(64'sh80000000)) rnd_sat = 32'sh80000000;
      else rnd_sat = q[31:0];
    end
  endfunction
endpackage

[rtl/core/pose_to_transform_matrix_unit.sv]
// Pose to 4x4 column-major transform matrix unit, top level.
// Depends on ptm_pkg, ptm_rot, ptm_mat.
// A new pose is taken only while busy is low; busy rises after an accepted start
// and holds off further starts. The four column transactions appear on
// consecutive cycles, columns 0..3, after the ptm_rot and ptm_mat register
// stages, paced by the one-column-per-cycle output.
// The receiver cannot stall; out_valid marks each column.
module pose_to_transform_matrix_unit import ptm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_op,
  input  logic signed [15:0] in_quat_w,
  input  logic signed [15:0] in_quat_x,
  input  logic signed [15:0] in_quat_y,
  input  logic signed [15:0] in_quat_z,
  input  logic signed [31:0] in_trans_x,
  input  logic signed [31:0] in_trans_y,
  input  logic signed [31:0] in_trans_z,
  input  logic signed [31:0] in_scale_x,
  input  logic signed [31:0] in_scale_y,
  input  logic signed [31:0] in_scale_z,
  output logic               out_valid,
  output logic [1:0]         out_column_index,
  output logic signed [31:0] out_row0_value,
  output logic signed [31:0] out_row1_value,
  output logic signed [31:0] out_row2_value,
  output logic signed [31:0] out_row3_value,
  output logic               out_last_column
);
  logic [1:0] gap_r;
  logic       acc;
  ctl_t       c0_r, c1_r;
  logic [2:0] vld_r;
  logic signed [31:0] t0_r [3], t1_r [3], s0_r [3], s1_r [3];
  rot_t       rm [3][3];
  logic signed [31:0] m [3][4];
  logic signed [31:0] hold_r [3][4];
  logic [1:0] col_r;
  logic       emit_r;

  assign busy = (gap_r != 2'd0);
  assign acc  = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r <= '0;
      c0_r  <= '0;
      c1_r  <= '0;
      vld_r <= '0;
    end else begin
      gap_r <= acc ? 2'd3 : (busy ? gap_r - 2'd1 : 2'd0);
      c0_r  <= '{valid: acc, view: in_op};
      c1_r  <= c0_r;
      vld_r <= {vld_r[1:0], c1_r.valid};
    end
  end

  always_ff @(posedge clk) begin
    t0_r <= '{in_trans_x, in_trans_y, in_trans_z};
    s0_r <= '{in_scale_x, in_scale_y, in_scale_z};
    t1_r <= t0_r;
    s1_r <= s0_r;
  end

  ptm_rot u_rot (.clk, .w(in_quat_w), .x(in_quat_x), .y(in_quat_y), .z(in_quat_z),
    .r_r(rm));
  ptm_mat u_mat (.clk, .view(c1_r.view), .r(rm), .t(t1_r), .s(s1_r), .m_r(m));

  // vld_r[2] marks the matrix at m; emit four columns from a hold copy
  always_ff @(posedge clk) begin
    if (vld_r[2]) hold_r <= m;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      emit_r <= 1'b0;
    end else if (vld_r[2]) begin
      col_r  <= '0;
      emit_r <= 1'b1;
    end else if (emit_r) begin
      col_r  <= col_r + 2'd1;
      emit_r <= (col_r != 2'd3);
    end
  end

  assign out_valid        = emit_r;
  assign out_column_index = col_r;
  assign out_last_column  = (col_r == 2'd3);
  assign out_row0_value   = hold_r[0][col_r];
  assign out_row1_value   = hold_r[1][col_r];
  assign out_row2_value   = hold_r[2][col_r];
  assign out_row3_value   = (col_r == 2'd3) ? ONE_OUT : 32'sd0;

`ifndef SYNTHESIS
  a_gap: assert property (@(posedge clk) disable iff (!rst_n) acc |=> busy)
    else $error("busy not raised after transaction");
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_column |=> !out_valid || out_column_index == 2'd0)
    else $error("column order broken");
  a_emit: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[2] |=> out_valid && out_column_index == 2'd0)
    else $error("matrix not emitted");
`endif
endmodule

[rtl/core/ptm_rot.sv]
// Quaternion to Q28 rotation matrix, two register stages (products, sums).
// Depends on ptm_pkg.
module ptm_rot import ptm_pkg::*; (
  input  logic               clk,
  input  logic signed [15:0] w,
  input  logic signed [15:0] x,
  input  logic signed [15:0] y,
  input  logic signed [15:0] z,
  output rot_t               r_r [3][3]
);
  logic signed [31:0] xx_r, yy_r, zz_r, xy_r, xz_r, yz_r, wx_r, wy_r, wz_r;
  localparam rot_t ONE28 = rot_t'(1 <<< 28);

  always_ff @(posedge clk) begin
    xx_r <= x * x; yy_r <= y * y; zz_r <= z * z;
    xy_r <= x * y; xz_r <= x * z; yz_r <= y * z;
    wx_r <= w * x; wy_r <= w * y; wz_r <= w * z;
  end

  function automatic rot_t d2(input logic signed [31:0] a, input logic signed [31:0] b);
    logic signed [33:0] s;
    begin
      s = 34'(a) + 34'(b);
      d2 = rot_t'(s <<< 1);
    end
  endfunction

  always_ff @(posedge clk) begin
    r_r[0][0] <= ONE28 - d2(yy_r, zz_r);
    r_r[1][1] <= ONE28 - d2(xx_r, zz_r);
    r_r[2][2] <= ONE28 - d2(xx_r, yy_r);
    r_r[1][0] <= d2(xy_r, wz_r);
    r_r[0][1] <= d2(xy_r, -wz_r);
    r_r[2][0] <= d2(xz_r, -wy_r);
    r_r[0][2] <= d2(xz_r, wy_r);
    r_r[2][1] <= d2(yz_r, wx_r);
    r_r[1][2] <= d2(yz_r, -wx_r);
  end
endmodule

[rtl/core/ptm_mat.sv]
// Matrix stage: products with scale or translation, sums, rounding.
// Depends on ptm_pkg.
module ptm_mat import ptm_pkg::*; (
  input  logic               clk,
  input  logic               view,
  input  rot_t               r [3][3],
  input  logic signed [31:0] t [3],
  input  logic signed [31:0] s [3],
  output logic signed [31:0] m_r [3][4]
);
  prod_t p_r [3][3];   // model: r[i][j]*s[j]; view: r[k][i]*t[k]
  rot_t  rv_r [3][3];
  logic  view_r, view2_r;
  logic signed [31:0] t_r [3], t2_r [3];
  acc_t  a_r [3][3];
  acc_t  sum_r [3];

  always_ff @(posedge clk) begin
    view_r <= view;
    for (int i = 0; i < 3; i++) begin
      t_r[i] <= t[i];
      for (int j = 0; j < 3; j++) begin
        rv_r[i][j] <= r[j][i];
        p_r[i][j]  <= view ? prod_t'(r[j][i]) * prod_t'(t[j])
                           : prod_t'(r[i][j]) * prod_t'(s[j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    view2_r <= view_r;
    for (int i = 0; i < 3; i++) begin
      t2_r[i]  <= t_r[i];
      sum_r[i] <= -(acc_t'(p_r[i][0]) + acc_t'(p_r[i][1]) + acc_t'(p_r[i][2]));
      for (int j = 0; j < 3; j++)
        a_r[i][j] <= view_r ? acc_t'(rv_r[i][j]) : acc_t'(p_r[i][j]);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++)
        m_r[i][j] <= view2_r ? rnd_sat(a_r[i][j], 28 - OUT_FRAC_BITS)
                             : rnd_sat(a_r[i][j], 44 - OUT_FRAC_BITS);
      m_r[i][3] <= view2_r ? rnd_sat(sum_r[i], 44 - OUT_FRAC_BITS)
                           : rnd_sat(acc_t'(t2_r[i]) <<< 16, 32 - OUT_FRAC_BITS);
    end
  end
endmodule
